### design/sorted_priority_queue_macros.svh
// Assertion macros for the sorted priority queue.
// Used by sorted_priority_queue; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// Clocked assertion, disabled while reset is asserted
`define SPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SPQ_ASSERT(label, clk, rst_n, prop, msg)
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue.
`default_nettype none

package spq_pkg;

    // Number of cells in the chain
    localparam int CAPACITY = 16;
    // Count width: must hold CAPACITY itself
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Fixed width of the occupancy field
    localparam int OCC_W    = 5;

    // Request codes
    localparam logic [1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [1:0] REQ_DEQUEUE = 2'd1;
    localparam logic [1:0] REQ_PEEK    = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] item_value;
        logic signed [31:0] item_priority;
    } request_t;

    typedef struct packed {
        logic signed [31:0] head_value;
        logic [1:0]         status;
        logic [OCC_W-1:0]   occupancy;
    } result_t;

    // One stored pair
    typedef struct packed {
        logic signed [31:0] ent_value;
        logic signed [31:0] ent_prio;
    } entry_t;

    // Broadcast from the control to every cell
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### design/spq_cell.sv
// One slot of the sorted chain: holds a (value, priority) pair.
// Depends on spq_pkg. Instantiated by sorted_priority_queue.
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       occupied,     // this slot holds a live entry
    input  wire logic       left_ge,      // left neighbor stays in place on enqueue
    input  wire entry_t     left_entry,   // entry of the higher-priority neighbor
    input  wire entry_t     right_entry,  // entry of the lower-priority neighbor
    output logic            ge,           // this slot stays in place on enqueue
    output entry_t          entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // Live entry with priority at least the new one keeps its slot
    assign ge = occupied && !(entry_reg.ent_prio < ctrl.new_entry.ent_prio);

    // Enqueue: keep, take the new pair, or shift right; dequeue: shift left
    always_comb
    begin
        priority if (ctrl.enq)
        begin
            priority if (ge)
                entry_next = entry_reg;
            else if (left_ge)
                entry_next = ctrl.new_entry;
            else
                entry_next = left_entry;
        end
        else if (ctrl.deq)
            entry_next = right_entry;
        else
            entry_next = entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

### design/sorted_priority_queue.sv
// Top level of the sorted priority queue: request decode, count, result register.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_macros.svh.
//
//  channel   handshake        payload              direction
//  request   start / busy     request (request_t)  in
//  result    done (strobe)    result  (result_t)   out
//
// On every request all cells compare against the new priority
// in parallel and shift or hold at the same clock edge.
// The result appears on the cycle after the request, for one cycle, with done.
// busy stays low, so a request may be issued every cycle.
// Reset clears the count and the strobe; cell contents are don't-care.
// The receiver cannot stall; results are never held back.
`default_nettype none
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue
    import spq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire request_t request,
    output logic          done,
    output result_t       result
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             done_next;
    result_t          result_reg;
    result_t          result_next;

    logic             accept;
    logic             full;
    logic             empty;
    logic             enq_ok;
    logic             deq_ok;
    cell_ctrl_t       ctrl;

    entry_t           cell_entry [CAPACITY];
    logic             cell_ge    [CAPACITY];
    logic             cell_occ   [CAPACITY];

    // One request per cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign enq_ok = accept && (request.req_type == REQ_ENQUEUE) && !full;
    assign deq_ok = accept && (request.req_type == REQ_DEQUEUE) && !empty;

    // Control broadcast to the chain
    always_comb
    begin
        ctrl.enq                 = enq_ok;
        ctrl.deq                 = deq_ok;
        ctrl.new_entry.ent_value = request.item_value;
        ctrl.new_entry.ent_prio  = request.item_priority;
    end

    // Chain of cells, head at index 0
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign cell_occ[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (cell_occ[i]),
                .left_ge     (1'b1),
                .left_entry  (ctrl.new_entry),
                .right_entry (cell_entry[i+1]),
                .ge          (cell_ge[i]),
                .entry       (cell_entry[i])
            );
        end
        else if (i == CAPACITY - 1)
        begin : g_tail
            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (cell_occ[i]),
                .left_ge     (cell_ge[i-1]),
                .left_entry  (cell_entry[i-1]),
                .right_entry (cell_entry[i]),
                .ge          (cell_ge[i]),
                .entry       (cell_entry[i])
            );
        end
        else
        begin : g_mid
            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (cell_occ[i]),
                .left_ge     (cell_ge[i-1]),
                .left_entry  (cell_entry[i-1]),
                .right_entry (cell_entry[i+1]),
                .ge          (cell_ge[i]),
                .entry       (cell_entry[i])
            );
        end
    end

    // Count update
    always_comb
    begin
        priority if (enq_ok)
            count_next = count_reg + CNT_W'(1);
        else if (deq_ok)
            count_next = count_reg - CNT_W'(1);
        else
            count_next = count_reg;
    end

    // Result for the accepted request
    always_comb
    begin
        done_next              = accept;
        result_next.head_value = '0;
        result_next.status     = ST_OK;
        result_next.occupancy  = OCC_W'(count_next);
        unique case (request.req_type)
            REQ_ENQUEUE:
            begin
                if (full)
                    result_next.status = ST_FULL;
            end
            REQ_DEQUEUE, REQ_PEEK:
            begin
                if (empty)
                    result_next.status = ST_EMPTY;
                else
                    result_next.head_value = cell_entry[0].ent_value;
            end
            default:
            begin
                result_next.status = ST_OK;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    `SPQ_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `SPQ_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !done, "result strobe during reset")
    `SPQ_ASSERT(a_done_follows, clk, rst_n, accept |=> done, "accepted request gave no result")
    `SPQ_ASSERT(a_full_status, clk, rst_n, (done && result.status == ST_FULL) |-> full, "full status while not full")
    `SPQ_ASSERT(a_empty_status, clk, rst_n, (done && result.status == ST_EMPTY) |-> empty, "empty status while not empty")
    `SPQ_ASSERT(a_head_order, clk, rst_n, cell_occ[1] |-> !(cell_entry[0].ent_prio < cell_entry[1].ent_prio), "head out of priority order")

endmodule

`default_nettype wire
